// ----- rtl/bmaj_pkg.sv -----
// Shared types and constants for the 3x3 binary majority smoothing block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package bmaj_pkg;

    // Port width of a row and number of column cells actually built.
    localparam int ROW_W     = 64;
    localparam int MAX_WIDTH = 64;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(1);

    // Rows held in the window.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Control broadcast from the sequencer to every column cell.
    typedef struct packed {
        logic load;        // shift column: upper <= middle, middle <= incoming
        logic mid_from_in; // center row is the incoming row (single-row frame)
        logic has_up;      // row above the center is in the grid
        logic has_down;    // row below the center (incoming row) is in the grid
    } t_cell_ctl;

    // One result transaction.
    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic             done;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/binary_majority_smooth_3x3_top.sv -----
// Top level of the 3x3 binary majority smoothing block.
// Depends on bmaj_pkg, bmaj_cell (column row) and bmaj_ofifo (result queue).
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  --------------------------------
//  input    in         i_valid / o_stall    i_row_cells, i_final_row
//  output   out        o_valid / i_stall    o_smoothed_cells, o_frame_done
//  config   in         i_cfg_we             i_cfg_data (row_width)
//
// One row transaction per cycle while o_stall is low; a final row behind held rows is
// followed by an end-of-frame step that produces the last smoothed row from the held rows.
// A row's smoothed result is written into the result queue when the row below it arrives
// (the last row of a multi-row frame: in the end-of-frame step) and is read out from there.
// Synchronous active-low reset clears the width to 64, the row count, the
// end-of-frame flag and the result queue. Column bits need no reset.
// o_stall rises when the two-entry result queue is full or the end-of-frame
// row is being produced; it comes from registers only.
`default_nettype none

module binary_majority_smooth_3x3_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [bmaj_pkg::ROW_W-1:0]   i_row_cells,
    input  wire                          i_final_row,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [bmaj_pkg::ROW_W-1:0]   o_smoothed_cells,
    output logic                         o_frame_done,
    input  wire                          i_cfg_we,
    input  wire  [bmaj_pkg::CFG_W-1:0]   i_cfg_data
);
    import bmaj_pkg::*;

    logic [CFG_W-1:0]     r_row_width;
    logic [CFG_W-1:0]     w_eff_width;
    logic [1:0]           r_held;
    logic [1:0]           n_held;
    logic                 r_flush;       // last smoothed row of a frame pending
    logic                 n_flush;
    logic                 w_acc;
    logic                 w_wr;
    logic                 w_full;
    t_cell_ctl            w_ctl;
    t_out_item            w_wdata;
    t_out_item            w_rdata;

    logic [MAX_WIDTH-1:0] w_in_range;
    logic [MAX_WIDTH-1:0] w_bits;
    logic [1:0]           w_cnt [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] w_cin;

    // Config register; software writes it only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_data;
        end
    end

    // Width 0 acts as 1, anything above MAX_WIDTH as MAX_WIDTH.
    always_comb begin
        w_eff_width = r_row_width;
        if (r_row_width < WIDTH_MIN)      w_eff_width = WIDTH_MIN;
        if (r_row_width > WIDTH_RESET)    w_eff_width = WIDTH_RESET;
    end

    assign o_stall = w_full || r_flush;
    assign w_acc   = i_valid && !o_stall;

    // Sequencer: rows held and the end-of-frame step.
    always_comb begin
        n_held  = r_held;
        n_flush = r_flush;
        w_wr    = 1'b0;
        w_wdata.cells = ROW_W'(w_bits);
        w_wdata.done  = 1'b0;
        if (r_flush) begin
            w_wr         = !w_full;
            w_wdata.done = 1'b1;
            if (!w_full) n_flush = 1'b0;
        end else if (w_acc) begin
            w_wr         = (r_held != HELD_NONE) || i_final_row;
            w_wdata.done = i_final_row && (r_held == HELD_NONE);
            if (i_final_row) begin
                n_held  = HELD_NONE;
                n_flush = (r_held != HELD_NONE);
            end else begin
                n_held  = (r_held == HELD_NONE) ? HELD_ONE : HELD_TWO;
            end
        end
    end

    always_comb begin
        if (r_flush) begin
            // last row of the frame: held rows are upper and center, none below
            w_ctl.load        = 1'b0;
            w_ctl.mid_from_in = 1'b0;
            w_ctl.has_up      = 1'b1;
            w_ctl.has_down    = 1'b0;
        end else begin
            w_ctl.load        = w_acc;
            w_ctl.mid_from_in = (r_held == HELD_NONE);
            w_ctl.has_up      = r_held[1];
            w_ctl.has_down    = (r_held != HELD_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= HELD_NONE;
            r_flush <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_flush <= n_flush;
        end
    end

    // Row of column cells; each sees its neighbors' wall counts.
    for (genvar n = 0; n < MAX_WIDTH; n++) begin : g_col
        assign w_in_range[n] = (CFG_W'(n) < w_eff_width);

        bmaj_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_in_range  (w_in_range[n]),
            .i_in_bit    (i_row_cells[n]),
            .i_left_cnt  ((n == 0) ? 2'd0 : w_cnt[(n == 0) ? 0 : n-1]),
            .i_left_in   ((n == 0) ? 1'b0 : w_cin[(n == 0) ? 0 : n-1]),
            .i_right_cnt ((n == MAX_WIDTH-1) ? 2'd0
                                              : w_cnt[(n == MAX_WIDTH-1) ? n : n+1]),
            .i_right_in  ((n == MAX_WIDTH-1) ? 1'b0
                                              : w_cin[(n == MAX_WIDTH-1) ? n : n+1]),
            .o_cnt       (w_cnt[n]),
            .o_in        (w_cin[n]),
            .o_bit       (w_bits[n])
        );
    end

    bmaj_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wdata),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rdata (w_rdata),
        .o_full  (w_full)
    );

    assign o_smoothed_cells = w_rdata.cells;
    assign o_frame_done     = w_rdata.done;

    // A final row arriving behind held rows always schedules the end-of-frame step.
    a_final_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_final_row && (r_held != HELD_NONE)) |=> r_flush)
        else $error("final row with held rows did not schedule last result");

    // While the last row is pending no rows are counted as held.
    a_flush_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_held == HELD_NONE))
        else $error("rows held during end-of-frame cycle");

    // The row count never reaches three.
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("row count out of range");

    // No accepted row writes a result into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !(w_acc && w_wr))
        else $error("result written to full queue");

endmodule

`default_nettype wire

// ----- rtl/bmaj_cell.sv -----
// One column cell: holds the column's upper and middle bits and smooths its bit.
// Depends on bmaj_pkg; neighbors exchange column wall counts each cycle.
`default_nettype none

module bmaj_cell (
    input  wire                  i_clk,
    input  wire bmaj_pkg::t_cell_ctl i_ctl,
    input  wire                  i_in_range,
    input  wire                  i_in_bit,
    input  wire  [1:0]           i_left_cnt,
    input  wire                  i_left_in,
    input  wire  [1:0]           i_right_cnt,
    input  wire                  i_right_in,
    output logic [1:0]           o_cnt,
    output logic                 o_in,
    output logic                 o_bit
);
    import bmaj_pkg::*;

    logic       r_up;
    logic       r_mid;
    logic       w_mid;
    logic [1:0] w_own;
    logic [3:0] w_walls;
    logic [1:0] w_ncols;
    logic [1:0] w_nrows;
    logic [3:0] w_total;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_up  <= r_mid;
            r_mid <= i_in_bit;
        end
    end

    always_comb begin
        w_mid   = i_ctl.mid_from_in ? i_in_bit : r_mid;
        w_own   = 2'({1'b0, r_up & i_ctl.has_up}) + 2'({1'b0, w_mid})
                + 2'({1'b0, i_in_bit & i_ctl.has_down});
        o_cnt   = i_in_range ? w_own : 2'd0;
        o_in    = i_in_range;
        w_walls = 4'(i_left_cnt) + 4'(o_cnt) + 4'(i_right_cnt);
        w_ncols = 2'd1 + 2'(i_left_in) + 2'(i_right_in);
        w_nrows = 2'd1 + 2'(i_ctl.has_up) + 2'(i_ctl.has_down);
        w_total = 4'(w_ncols) * 4'(w_nrows);
        // wall unless non-walls outnumber walls: total > 2*walls means floor
        o_bit   = i_in_range && !(5'(w_total) > {w_walls, 1'b0});
    end

endmodule

`default_nettype wire

// ----- rtl/bmaj_ofifo.sv -----
// Two-entry result queue between the cell row and the output channel.
// Depends on bmaj_pkg for the result item type.
`default_nettype none

module bmaj_ofifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  wire bmaj_pkg::t_out_item i_wdata,
    input  wire                  i_stall,
    output logic                 o_valid,
    output bmaj_pkg::t_out_item  o_rdata,
    output logic                 o_full
);
    import bmaj_pkg::*;

    t_out_item  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_rdata = r_q[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_wr && !w_pop) n_count = r_count + 2'd1;
        if (!i_wr && w_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr)  r_wr_ptr <= !r_wr_ptr;
            if (w_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
